[sv/gno_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gno_pkg: shared types and constants
// Item kinds and configuration register indexes used by the top level and
// the bench.
// ----------------------------------------------------------------------------
package gno_pkg;

    localparam logic [1:0] KIND_PERM = 2'd0;
    localparam logic [1:0] KIND_GRAD = 2'd1;
    localparam logic [1:0] KIND_EVAL = 2'd2;

    localparam logic [0:0] REG_DIMS = 1'd0;
    localparam logic [0:0] REG_OCT  = 1'd1;

endpackage

[sv/gno_scurve.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gno_scurve: s-curve evaluator
// Computes round(f*f*(3*2^16-2f)/2^32) over two registered steps.
// ----------------------------------------------------------------------------
module gno_scurve (
    input  logic        i_clk,
    input  logic        i_start,
    input  logic [15:0] i_frac,
    output logic [16:0] o_s
);
    logic [31:0] r_sq;
    logic [17:0] r_w;
    logic [16:0] r_s;
    logic [49:0] w_p;

    // step 1: square and weight term; step 2: product and round
    assign w_p = r_sq * r_w;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sq <= i_frac * i_frac;
            r_w  <= 18'(3 * 65536) - {1'b0, i_frac, 1'b0};
        end
        r_s <= 17'((w_p + 50'(33'h80000000)) >> 32);
    end

    assign o_s = r_s;
endmodule

[sv/gno_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gno_core: noise sequencer with one shared multiplier
// Walks corners and blends of each octave, one multiply per cycle, and
// accumulates the weighted octave sum. Holds in the rounding step while
// i_stall is high.
// ----------------------------------------------------------------------------
module gno_core #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_stall,
    input  logic [1:0]  i_dims,
    input  logic [3:0]  i_octs,
    input  logic [23:0] i_cx,
    input  logic [23:0] i_cy,
    input  logic [23:0] i_cz,
    // table write side
    input  logic        i_we_perm,
    input  logic        i_we_grad,
    input  logic [7:0]  i_widx,
    input  logic [7:0]  i_perm,
    input  logic [15:0] i_g1,
    input  logic [15:0] i_gx,
    input  logic [15:0] i_gy,
    input  logic [15:0] i_gz,
    input  logic [15:0] i_g2x,
    input  logic [15:0] i_g2y,
    output logic        o_done,
    output logic [16:0] o_value
);
    localparam int OW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES + 1) : 1;
    localparam int AW = 40 + MAX_OCTAVES;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_SC    = 8'b00000010,
        S_PERM  = 8'b00000100,
        S_HASH  = 8'b00001000,
        S_CORN  = 8'b00010000,
        S_BLEND = 8'b00100000,
        S_ACC   = 8'b01000000,
        S_FIN   = 8'b10000000
    } t_state;

    // memories
    logic [7:0]  r_perm_mem [256];
    logic [15:0] r_g1_mem [256];
    logic [31:0] r_g2_mem [256];
    logic [47:0] r_g3_mem [256];

    t_state      r_state;
    logic [3:0]  r_step;
    logic [2:0]  r_cnt;
    logic [OW-1:0] r_oct, r_noct;
    logic [1:0]  r_dims;
    logic [23:0] r_cx, r_cy, r_cz;
    logic [7:0]  r_praddr, r_prdata;
    logic [7:0]  r_i, r_j;
    logic [7:0]  r_b [4];
    logic [7:0]  r_gaddr;
    logic [15:0] r_g1d;
    logic [31:0] r_g2d;
    logic [47:0] r_g3d;
    logic [16:0] r_sx, r_sy, r_sz;
    logic signed [40:0] r_dot;
    logic signed [40:0] r_val [8];
    logic signed [AW-1:0] r_acc;
    logic [16:0] r_out;
    logic        r_done;
    logic [1:0]  r_sc_ph;
    logic [1:0]  r_sc_ax;
    logic [16:0] w_s;
    logic        w_sc_go;
    logic [15:0] w_sc_f;

    // shared multiply: 18-bit signed times 42-bit signed
    logic signed [17:0] w_ma;
    logic signed [41:0] w_mb;
    logic signed [59:0] w_prod;
    assign w_prod = w_ma * w_mb;

    gno_scurve u_sc (
        .i_clk  (i_clk),
        .i_start(w_sc_go),
        .i_frac (w_sc_f),
        .o_s    (w_s)
    );
    assign w_sc_go = (r_state == S_SC) && (r_sc_ph == 2'd0);
    assign w_sc_f  = (r_sc_ax == 2'd0) ? r_cx[15:0] :
                     (r_sc_ax == 2'd1) ? r_cy[15:0] : r_cz[15:0];

    // table writes and registered reads
    always_ff @(posedge i_clk) begin
        if (i_we_perm) r_perm_mem[i_widx] <= i_perm;
        if (i_we_grad) begin
            r_g1_mem[i_widx] <= i_g1;
            r_g2_mem[i_widx] <= {i_g2y, i_g2x};
            r_g3_mem[i_widx] <= {i_gz, i_gy, i_gx};
        end
        r_prdata <= r_perm_mem[r_praddr];
        r_g1d    <= r_g1_mem[r_gaddr];
        r_g2d    <= r_g2_mem[r_gaddr];
        r_g3d    <= r_g3_mem[r_gaddr];
    end

    // corner geometry for corner c (bit0 x, bit1 y, bit2 z)
    logic [2:0]  w_c;
    logic signed [17:0] w_rx, w_ry, w_rz;
    assign w_c  = r_step[2:0];
    assign w_rx = w_c[0] ? $signed({2'b11, r_cx[15:0]}) : $signed({2'b00, r_cx[15:0]});
    assign w_ry = w_c[1] ? $signed({2'b11, r_cy[15:0]}) : $signed({2'b00, r_cy[15:0]});
    assign w_rz = w_c[2] ? $signed({2'b11, r_cz[15:0]}) : $signed({2'b00, r_cz[15:0]});

    logic [7:0] w_bx0, w_by0, w_bz0, w_bz;
    assign w_bx0 = r_cx[23:16];
    assign w_by0 = r_cy[23:16];
    assign w_bz0 = r_cz[23:16];
    assign w_bz  = w_bz0 + 8'(w_c[2]);

    // multiplier operand select
    logic [1:0]  w_comp;
    logic signed [15:0] w_gsel;
    logic signed [40:0] w_la, w_lb;
    logic signed [41:0] w_diff;
    logic [16:0] w_lw;
    always_comb begin
        w_comp = r_cnt[1:0];
        w_gsel = '0;
        w_ma   = '0;
        w_mb   = '0;
        w_la   = '0;
        w_lb   = '0;
        w_lw   = r_sx;
        w_diff = '0;
        if (r_state == S_CORN) begin
            case (w_comp)
                2'd0: begin
                    w_gsel = (r_dims == 2'd1) ? $signed(r_g1d) :
                             (r_dims == 2'd2) ? $signed(r_g2d[15:0]) : $signed(r_g3d[15:0]);
                    w_ma = w_rx;
                end
                2'd1: begin
                    w_gsel = (r_dims == 2'd2) ? $signed(r_g2d[31:16]) : $signed(r_g3d[31:16]);
                    w_ma = w_ry;
                end
                default: begin
                    w_gsel = $signed(r_g3d[47:32]);
                    w_ma = w_rz;
                end
            endcase
            w_mb = 42'(w_gsel);
        end else begin
            // blend order: (0,1)->0 (2,3)->2 (4,5)->4 (6,7)->6 with sx;
            // (0,2)->0 (4,6)->4 with sy; (0,4)->0 with sz
            case (r_step)
                4'd0: begin w_la = r_val[0]; w_lb = r_val[1]; w_lw = r_sx; end
                4'd1: begin w_la = r_val[2]; w_lb = r_val[3]; w_lw = r_sx; end
                4'd2: begin w_la = r_val[4]; w_lb = r_val[5]; w_lw = r_sx; end
                4'd3: begin w_la = r_val[6]; w_lb = r_val[7]; w_lw = r_sx; end
                4'd4: begin w_la = r_val[0]; w_lb = r_val[2]; w_lw = r_sy; end
                4'd5: begin w_la = r_val[4]; w_lb = r_val[6]; w_lw = r_sy; end
                default: begin w_la = r_val[0]; w_lb = r_val[4]; w_lw = r_sz; end
            endcase
            w_diff = 42'(w_lb) - 42'(w_la);
            w_ma   = $signed({1'b0, w_lw});
            w_mb   = w_diff;
        end
    end

    logic signed [59:0] w_lr;
    logic signed [40:0] w_blend;
    assign w_lr    = (w_prod + 60'sd32768) >>> 16;
    assign w_blend = w_la + 41'(w_lr);

    // corner count and final blend slot for the current dimension
    logic [3:0] w_ncorn;
    logic [3:0] w_blast;
    always_comb begin
        case (r_dims)
            2'd2:    begin w_ncorn = 4'd4; w_blast = 4'd4; end
            2'd3:    begin w_ncorn = 4'd8; w_blast = 4'd6; end
            default: begin w_ncorn = 4'd2; w_blast = 4'd0; end
        endcase
    end
    logic [3:0] w_bnext;
    always_comb begin
        case (r_step)
            4'd0:    w_bnext = (r_dims == 2'd3) ? 4'd1 : (r_dims == 2'd2) ? 4'd1 : 4'd0;
            4'd1:    w_bnext = (r_dims == 2'd3) ? 4'd2 : 4'd4;
            4'd2:    w_bnext = 4'd3;
            4'd3:    w_bnext = 4'd4;
            4'd4:    w_bnext = 4'd5;
            default: w_bnext = 4'd6;
        endcase
    end

    // weighted octave term
    logic signed [AW-1:0] w_term;
    assign w_term = AW'(r_val[0]) <<< (OW'(MAX_OCTAVES - 1) - r_oct);
    logic signed [AW-1:0] w_q;
    assign w_q = (r_acc + (AW'(1) <<< (15 + MAX_OCTAVES - 1))) >>> (16 + MAX_OCTAVES - 1);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cx   <= i_cx;
                        r_cy   <= i_cy;
                        r_cz   <= i_cz;
                        r_dims <= (i_dims == 2'd0) ? 2'd1 : i_dims;
                        r_noct <= (32'(i_octs) > MAX_OCTAVES) ? OW'(MAX_OCTAVES) : OW'(i_octs);
                        r_oct  <= '0;
                        r_acc  <= '0;
                        if (i_octs == 4'd0) r_state <= S_FIN;
                        else begin
                            r_state <= S_SC;
                            r_sc_ph <= '0;
                            r_sc_ax <= '0;
                        end
                    end
                end
                S_SC: begin
                    // three s-curves, one per axis, computed in turn
                    r_sc_ph <= (r_sc_ph == 2'd2) ? 2'd0 : r_sc_ph + 2'd1;
                    if (r_sc_ph == 2'd2) begin
                        case (r_sc_ax)
                            2'd0:    r_sx <= w_s;
                            2'd1:    r_sy <= w_s;
                            default: r_sz <= w_s;
                        endcase
                        r_sc_ax <= r_sc_ax + 2'd1;
                        if (r_sc_ax == 2'd2) begin
                            r_state  <= S_PERM;
                            r_cnt    <= '0;
                            r_praddr <= w_bx0;
                        end
                    end
                end
                S_PERM: begin
                    // perm[bx0], perm[bx1]; then hashes for y
                    r_cnt <= r_cnt + 3'd1;
                    case (r_cnt)
                        3'd0: r_praddr <= w_bx0 + 8'd1;
                        3'd1: begin
                            r_i <= r_prdata;
                            r_praddr <= r_prdata + w_by0;
                        end
                        3'd2: begin
                            r_j <= r_prdata;
                            r_praddr <= r_prdata + w_by0;
                            if (r_dims == 2'd1) begin
                                r_b[0] <= r_i;
                                r_b[1] <= r_prdata;
                                r_state <= S_HASH;
                            end
                        end
                        3'd3: begin
                            r_b[0] <= r_prdata;
                            r_praddr <= r_i + w_by0 + 8'd1;
                        end
                        3'd4: begin
                            r_b[1] <= r_prdata;
                            r_praddr <= r_j + w_by0 + 8'd1;
                        end
                        3'd5: r_b[2] <= r_prdata;
                        default: begin
                            r_b[3] <= r_prdata;
                            r_state <= S_HASH;
                        end
                    endcase
                    if (r_state == S_PERM && (r_cnt == 3'd6 ||
                        (r_cnt == 3'd2 && r_dims == 2'd1))) begin
                        r_step <= '0;
                        r_cnt  <= '0;
                    end
                end
                S_HASH: begin
                    // present gradient address, wait one read
                    r_gaddr <= r_b[r_step[1:0]] + ((r_dims == 2'd3) ? w_bz : 8'd0);
                    r_cnt   <= r_cnt + 3'd1;
                    if (r_cnt == 3'd1) begin
                        r_state <= S_CORN;
                        r_cnt   <= '0;
                    end
                end
                S_CORN: begin
                    // one dot-product term per cycle
                    r_dot <= (r_cnt == 3'd0) ? 41'(w_prod) : r_dot + 41'(w_prod);
                    if (r_cnt == 3'(r_dims) - 3'd1) begin
                        r_val[r_step[2:0]] <= (r_cnt == 3'd0) ? 41'(w_prod) : r_dot + 41'(w_prod);
                        r_cnt <= '0;
                        if (r_step + 4'd1 == w_ncorn) begin
                            r_state <= S_BLEND;
                            r_step  <= '0;
                        end else begin
                            r_step  <= r_step + 4'd1;
                            r_state <= S_HASH;
                        end
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_BLEND: begin
                    case (r_step)
                        4'd0, 4'd4: r_val[0] <= w_blend;
                        4'd1: r_val[2] <= w_blend;
                        4'd2, 4'd5: r_val[4] <= w_blend;
                        4'd3: r_val[6] <= w_blend;
                        default: r_val[0] <= w_blend;
                    endcase
                    if (r_step == w_blast) r_state <= S_ACC;
                    else r_step <= w_bnext;
                end
                S_ACC: begin
                    r_acc <= r_acc + w_term;
                    r_cx  <= {r_cx[22:0], 1'b0};
                    r_cy  <= {r_cy[22:0], 1'b0};
                    r_cz  <= {r_cz[22:0], 1'b0};
                    r_oct <= r_oct + OW'(1);
                    if (r_oct + OW'(1) == r_noct) r_state <= S_FIN;
                    else begin
                        r_state <= S_SC;
                        r_sc_ph <= '0;
                        r_sc_ax <= '0;
                    end
                end
                S_FIN: begin
                    // wait here while the previous result is still held
                    if (!i_stall) begin
                        if (w_q > AW'(65535)) r_out <= 17'h0FFFF;
                        else if (w_q < -AW'(65536)) r_out <= 17'h10000;
                        else r_out <= w_q[16:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_value = r_out;

`ifndef NO_ASSERTIONS
    a_done_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_FIN)) else $error("done without finish");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == S_IDLE) |=> (r_state != S_IDLE)) else $error("start lost");
    a_oct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_oct < r_noct)) else $error("octave overrun");
`endif
endmodule

[sv/gradient_noise_octaves.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_noise_octaves: lattice gradient noise summed over octaves
// Top level: input handshake, config registers and output register.
// ----------------------------------------------------------------------------
// Usage: items enter on i_valid/o_ready. Kind 0 writes the permutation table,
// kind 1 writes the gradient tables; both are written on accept, no result.
// Kind 2 evaluates noise at (coord_x, coord_y, coord_z) and yields one
// noise_value on o_valid/i_ready. Per octave the sequencer computes the
// s-curves, reads the permutation table, then per corner reads a gradient
// and does one multiply per axis, then one multiply per blend, then one
// accumulate; one shared multiplier serves these multiplies. After the last
// octave, or after the accept with zero octaves, the result passes the
// rounding step and the output register before o_valid rises. o_ready is
// low while an evaluation runs. A new item is taken while a result waits;
// if the next result is due before the held one is taken, the sequencer
// holds in its rounding step and the input stays blocked. Reset sets
// dimensions to 3 and octaves to 1; tables are undefined until written.
// Config writes must be made only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module gradient_noise_octaves #(
    parameter int MAX_OCTAVES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_index,
    input  logic [7:0]  i_perm_value,
    input  logic signed [15:0] i_grad_one,
    input  logic signed [15:0] i_grad_x,
    input  logic signed [15:0] i_grad_y,
    input  logic signed [15:0] i_grad_z,
    input  logic signed [15:0] i_grad2_x,
    input  logic signed [15:0] i_grad2_y,
    input  logic [23:0] i_coord_x,
    input  logic [23:0] i_coord_y,
    input  logic [23:0] i_coord_z,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [16:0] o_noise_value
);
    logic [1:0]  r_dims;
    logic [3:0]  r_octs;
    logic        r_busy;
    logic        r_ovalid;
    logic [16:0] r_onoise;
    logic        w_acc;
    logic        w_done;
    logic [16:0] w_val;
    logic        w_eval;
    logic        w_stall;

    assign o_ready = !r_busy;
    assign w_acc   = i_valid && o_ready;
    assign w_eval  = w_acc && i_kind == gno_pkg::KIND_EVAL;
    assign w_stall = r_ovalid && !i_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 2'd3;
            r_octs <= 4'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gno_pkg::REG_DIMS: r_dims <= i_cfg_data[1:0];
                gno_pkg::REG_OCT:  r_octs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gno_core #(.MAX_OCTAVES(MAX_OCTAVES)) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_eval),
        .i_stall  (w_stall),
        .i_dims   (r_dims),
        .i_octs   (r_octs),
        .i_cx     (i_coord_x),
        .i_cy     (i_coord_y),
        .i_cz     (i_coord_z),
        .i_we_perm(w_acc && i_kind == gno_pkg::KIND_PERM),
        .i_we_grad(w_acc && i_kind == gno_pkg::KIND_GRAD),
        .i_widx   (i_index),
        .i_perm   (i_perm_value),
        .i_g1     (i_grad_one),
        .i_gx     (i_grad_x),
        .i_gy     (i_grad_y),
        .i_gz     (i_grad_z),
        .i_g2x    (i_grad2_x),
        .i_g2y    (i_grad2_y),
        .o_done   (w_done),
        .o_value  (w_val)
    );

    // busy flag and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_eval) r_busy <= 1'b1;
            else if (w_done) r_busy <= 1'b0;
            if (w_done) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
        end
        if (w_done) r_onoise <= w_val;
    end

    assign o_valid       = r_ovalid;
    assign o_noise_value = r_onoise;

`ifndef NO_ASSERTIONS
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> !r_ovalid || i_ready) else $error("result overwritten");
    a_busy_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !o_ready) else $error("ready while busy");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy) else $error("done while idle");
`endif
endmodule

[tb/sv/tb_gradient_noise_octaves.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gradient_noise_octaves: self-checking bench for the octave gradient noise
// Fills every permutation and gradient entry, then runs directed and random
// load and evaluate items over many dimension/octave settings. Every noise
// value is checked against a lattice noise predictor kept in the bench.
// Idling on both sides varies by phase.
// ----------------------------------------------------------------------------
module tb_gradient_noise_octaves;

    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int LONG_HOLD = 400;
    localparam int DIMS_SET [10] = '{1, 2, 3, 3, 0, 2, 1, 3, 2, 3};
    localparam int OCT_SET  [10] = '{1, 1, 1, 2, 4, 8, 15, 0, 3, 8};
    localparam int LEN_SET  [10] = '{14, 14, 12, 12, 12, 12, 12, 10, 12, 10};

    typedef struct {
        logic [1:0]         kind;
        logic [7:0]         index;
        logic [7:0]         perm_value;
        logic signed [15:0] grad_one, grad_x, grad_y, grad_z, grad2_x, grad2_y;
        logic [23:0]        coord_x, coord_y, coord_z;
    } t_noise_item;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_kind = '0;
    logic [7:0] i_index = '0;
    logic [7:0] i_perm_value = '0;
    logic signed [15:0] i_grad_one = '0, i_grad_x = '0, i_grad_y = '0, i_grad_z = '0;
    logic signed [15:0] i_grad2_x = '0, i_grad2_y = '0;
    logic [23:0] i_coord_x = '0, i_coord_y = '0, i_coord_z = '0;
    logic i_cfg_we = 1'b0;
    logic [0:0] i_cfg_index = '0;
    logic [3:0] i_cfg_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [16:0] o_noise_value;

    gradient_noise_octaves dut (.*);

    // Predictor state
    logic [1:0]         cur_dims = 2'd3;
    logic [3:0]         cur_octaves = 4'd1;
    logic [7:0]         perm_tab [256];
    logic signed [15:0] g1_tab [256];
    logic signed [15:0] g2x_tab [256], g2y_tab [256];
    logic signed [15:0] g3x_tab [256], g3y_tab [256], g3z_tab [256];

    t_noise_item        pending_items [$];
    logic signed [16:0] expected_noise [$];
    t_noise_item        driven;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  errors = 0;
    int  quiet_cycles = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---- predictor ----
    function automatic longint round_shift(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint fade(longint f);
        longint p;
        p = f * f * (3 * 65536 - 2 * f);
        return (p + (longint'(1) << 31)) >>> 32;
    endfunction

    function automatic longint mix(longint s, longint a, longint b);
        return a + round_shift(s * (b - a), 16);
    endfunction

    function automatic longint dot3(longint rx, longint ry, longint rz, logic [7:0] e);
        return rx * g3x_tab[e] + ry * g3y_tab[e] + rz * g3z_tab[e];
    endfunction

    function automatic longint lattice(logic [1:0] dims, logic [23:0] cx, logic [23:0] cy,
                                       logic [23:0] cz);
        logic [7:0] bx0, bx1, by0, by1, bz, pi, pj, b00, b10, b01, b11;
        longint rx0, rx1, ry0, ry1, rz, sx, sy, sz, a, b;
        longint layer [2];
        bx0 = cx[23:16]; bx1 = 8'(bx0 + 1);
        by0 = cy[23:16]; by1 = 8'(by0 + 1);
        rx0 = cx[15:0]; rx1 = rx0 - 65536;
        ry0 = cy[15:0]; ry1 = ry0 - 65536;
        sx = fade(rx0); sy = fade(ry0); sz = fade(longint'(cz[15:0]));
        if (dims <= 2'd1) begin
            return mix(sx, rx0 * g1_tab[perm_tab[bx0]], rx1 * g1_tab[perm_tab[bx1]]);
        end
        pi = perm_tab[bx0];
        pj = perm_tab[bx1];
        b00 = perm_tab[8'(pi + by0)];
        b10 = perm_tab[8'(pj + by0)];
        b01 = perm_tab[8'(pi + by1)];
        b11 = perm_tab[8'(pj + by1)];
        if (dims == 2'd2) begin
            a = mix(sx, rx0 * g2x_tab[b00] + ry0 * g2y_tab[b00],
                        rx1 * g2x_tab[b10] + ry0 * g2y_tab[b10]);
            b = mix(sx, rx0 * g2x_tab[b01] + ry1 * g2y_tab[b01],
                        rx1 * g2x_tab[b11] + ry1 * g2y_tab[b11]);
            return mix(sy, a, b);
        end
        for (int k = 0; k < 2; k++) begin
            bz = 8'(cz[23:16] + k);
            rz = longint'(cz[15:0]) - (k ? 65536 : 0);
            a = mix(sx, dot3(rx0, ry0, rz, 8'(b00 + bz)), dot3(rx1, ry0, rz, 8'(b10 + bz)));
            b = mix(sx, dot3(rx0, ry1, rz, 8'(b01 + bz)), dot3(rx1, ry1, rz, 8'(b11 + bz)));
            layer[k] = mix(sy, a, b);
        end
        return mix(sz, layer[0], layer[1]);
    endfunction

    // Apply one accepted item to the tables, or queue its noise value
    function automatic void predict_item(t_noise_item it);
        longint acc, q;
        int n;
        logic [23:0] cx, cy, cz;
        case (it.kind)
            gno_pkg::KIND_PERM: perm_tab[it.index] = it.perm_value;
            gno_pkg::KIND_GRAD: begin
                g1_tab[it.index] = it.grad_one;
                g3x_tab[it.index] = it.grad_x;
                g3y_tab[it.index] = it.grad_y;
                g3z_tab[it.index] = it.grad_z;
                g2x_tab[it.index] = it.grad2_x;
                g2y_tab[it.index] = it.grad2_y;
            end
            gno_pkg::KIND_EVAL: begin
                n = (cur_octaves > 8) ? 8 : cur_octaves;
                acc = 0;
                cx = it.coord_x; cy = it.coord_y; cz = it.coord_z;
                for (int k = 0; k < n; k++) begin
                    acc += lattice(cur_dims, cx, cy, cz) * (longint'(1) << (7 - k));
                    cx = cx << 1; cy = cy << 1; cz = cz << 1;
                end
                q = round_shift(acc, 23);
                if (q > 65535) q = 65535;
                if (q < -65536) q = -65536;
                expected_noise.push_back(17'(q));
            end
            default: ;
        endcase
    endfunction

    // ---- driver ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid) predict_item(driven);
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                driven = pending_items.pop_front();
                i_valid <= 1'b1;
                i_kind <= driven.kind;
                i_index <= driven.index;
                i_perm_value <= driven.perm_value;
                i_grad_one <= driven.grad_one;
                i_grad_x <= driven.grad_x;
                i_grad_y <= driven.grad_y;
                i_grad_z <= driven.grad_z;
                i_grad2_x <= driven.grad2_x;
                i_grad2_y <= driven.grad2_y;
                i_coord_x <= driven.coord_x;
                i_coord_y <= driven.coord_y;
                i_coord_z <= driven.coord_z;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // ---- monitor and receiver stalls ----
    always @(posedge i_clk) begin
        logic signed [16:0] want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_noise.size() == 0) begin
                    $display("%0t: unexpected noise value %0d", $time, o_noise_value);
                    errors++;
                end else begin
                    want = expected_noise.pop_front();
                    if (want !== o_noise_value) begin
                        $display("%0t: noise_value expected %0d actual %0d",
                                 $time, want, o_noise_value);
                        errors++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                hold_done = 1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ---- watchdog on cycles with no accepted item or result ----
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---- stimulus ----
    function automatic t_noise_item blank_item(logic [1:0] kind);
        t_noise_item it;
        it.kind = kind;
        it.index = 8'($urandom);
        it.perm_value = 8'($urandom);
        it.grad_one = 16'($urandom);
        it.grad_x = 16'($urandom);
        it.grad_y = 16'($urandom);
        it.grad_z = 16'($urandom);
        it.grad2_x = 16'($urandom);
        it.grad2_y = 16'($urandom);
        it.coord_x = 24'($urandom);
        it.coord_y = 24'($urandom);
        it.coord_z = 24'($urandom);
        return it;
    endfunction

    function automatic logic [23:0] pick_coord();
        logic [23:0] c;
        c = 24'($urandom);
        case ($urandom_range(7))
            0: c[15:0] = 16'h0000;
            1: c[15:0] = 16'hFFFF;
            2: c[23:16] = 8'hFF;
            default: ;
        endcase
        return c;
    endfunction

    task automatic queue_eval(logic [23:0] x, logic [23:0] y, logic [23:0] z);
        t_noise_item it;
        it = blank_item(gno_pkg::KIND_EVAL);
        it.coord_x = x; it.coord_y = y; it.coord_z = z;
        pending_items.push_back(it);
    endtask

    task automatic queue_random(int count);
        t_noise_item it;
        int r;
        @(negedge i_clk);
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 70) begin
                queue_eval(pick_coord(), pick_coord(), pick_coord());
            end else begin
                it = blank_item(r < 88 ? gno_pkg::KIND_GRAD :
                                (r < 97 ? gno_pkg::KIND_PERM : KIND_NONE));
                if ($urandom_range(9) == 0) it.grad_x = 16'sh7FFF;
                if ($urandom_range(9) == 0) it.grad2_y = -16'sh8000;
                pending_items.push_back(it);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || i_valid || expected_noise.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [3:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        cur_dims = (idx == gno_pkg::REG_DIMS) ? value[1:0] : cur_dims;
        cur_octaves = (idx == gno_pkg::REG_OCT) ? value : cur_octaves;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_idling(int mode);
        @(posedge i_clk);
        case (mode % 4)
            0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
            1: begin send_idle_pct <= 76; recv_stall_pct <= 0;  end
            2: begin send_idle_pct <= 0;  recv_stall_pct <= 76; end
            default: begin send_idle_pct <= 8; recv_stall_pct <= 8; end
        endcase
    endtask

    initial begin
        t_noise_item it;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fill every table entry; every fourth gradient entry at the Q1.15 extremes
        @(negedge i_clk);
        for (int e = 0; e < 256; e++) begin
            it = blank_item(gno_pkg::KIND_PERM);
            it.index = 8'(e);
            it.perm_value = (e % 5 == 0) ? 8'hFF : (e % 7 == 0 ? 8'h00 : it.perm_value);
            pending_items.push_back(it);
            it = blank_item(gno_pkg::KIND_GRAD);
            it.index = 8'(e);
            if (e % 4 == 0) begin
                it.grad_one = 16'sh7FFF; it.grad_x = 16'sh7FFF; it.grad_y = -16'sh8000;
                it.grad_z = 16'sh7FFF; it.grad2_x = -16'sh8000; it.grad2_y = 16'sh7FFF;
            end
            pending_items.push_back(it);
        end
        wait_drained();

        // Directed: coordinate extremes over each dimension count
        for (int d = 1; d <= 3; d++) begin
            write_reg(gno_pkg::REG_DIMS, 4'(d));
            write_reg(gno_pkg::REG_OCT, (d == 3) ? 4'd8 : 4'd2);
            @(negedge i_clk);
            queue_eval(24'h000000, 24'h000000, 24'h000000);
            queue_eval(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
            queue_eval(24'hFF8000, 24'h00FFFF, 24'h7F0001);
            queue_eval(24'h010000, 24'hFF0000, 24'h800000);
            it = blank_item(KIND_NONE);
            pending_items.push_back(it);
            queue_eval(24'h123456, 24'hABCDEF, 24'h555555);
            wait_drained();
        end

        // Random phases over settings and idling; long stall in one phase
        for (int p = 0; p < 10; p++) begin
            write_reg(gno_pkg::REG_DIMS, 4'(DIMS_SET[p]));
            write_reg(gno_pkg::REG_OCT, 4'(OCT_SET[p]));
            set_idling(p);
            if (p == 1) hold_req <= 1'b1;
            queue_random(LEN_SET[p]);
            // sender pauses here until every pending noise value is back
            wait_drained();
        end

        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_noise.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[gradient_noise_octaves.f]
sv/gno_pkg.sv
sv/gno_scurve.sv
sv/gno_core.sv
sv/gradient_noise_octaves.sv
tb/sv/tb_gradient_noise_octaves.sv
